// ===== sv/assert_macros.svh =====
// Assertion macros used by the checker file.
// All take the clock; the first two take the reset, active low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, off during reset.
`define PTI_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, off during reset.
`define PTI_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

// Next-cycle implication that is also checked through reset.
`define PTI_ASSERT_NEXT_ALWAYS(label, clk, ante, cons, msg) \
    label: assert property (@(posedge clk) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== sv/pti_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pti_pkg
// Shared types and constants of the periodic table interpolator.
// ----------------------------------------------------------------------------
package pti_pkg;

    // Table geometry
    localparam int TABLE_ROWS = 4096;
    localparam int VALUE_BITS = 32;
    localparam int ROW_AW     = $clog2(TABLE_ROWS);
    localparam int BANK_DEPTH = TABLE_ROWS / 2;
    localparam int BANK_AW    = ROW_AW - 1;
    localparam int ROW_BITS   = 2 * VALUE_BITS;

    // Port field widths
    localparam int FIELD_W    = 32;
    localparam int IDX_W      = 12;

    // Day reduction: 24 h in Q16.16 is 3 << 19
    localparam int DAY_SHIFT  = 19;
    localparam int MOD3_IN_W  = FIELD_W - DAY_SHIFT;
    localparam int MOD3_SHIFT = 13;
    localparam int MOD3_RECIP = 2731;   // ceil(2^13 / 3)
    localparam int TDAY_W     = DAY_SHIFT + 2;

    // Row position: t * (ROWS-1) / 24 == t * ((ROWS-1)/3) >> 3
    localparam int ROW_SCALE   = (TABLE_ROWS - 1) / 3;
    localparam int SCALE_SHIFT = 3;
    localparam int FRAC_W      = 16;
    localparam int POS_PROD_W  = TDAY_W + $clog2(ROW_SCALE + 1);

    // Result queue
    localparam int FIFO_DEPTH = 8;
    localparam int FIFO_AW    = $clog2(FIFO_DEPTH);

    typedef enum logic {
        FUNC_WRITE = 1'b0,
        FUNC_QUERY = 1'b1
    } t_func;

endpackage

// ===== sv/pti_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pti_req_if / pti_rsp_if
// Valid/ready channels carrying request and result words.
// ----------------------------------------------------------------------------
interface pti_req_if;
    import pti_pkg::*;

    logic                valid;
    logic                ready;
    t_func               func;
    logic [IDX_W-1:0]    row_index;
    logic signed [FIELD_W-1:0] value_a;
    logic signed [FIELD_W-1:0] value_b;
    logic [FIELD_W-1:0]  query_time;

    modport source (output valid, func, row_index, value_a, value_b, query_time,
                    input ready);
    modport sink   (input valid, func, row_index, value_a, value_b, query_time,
                    output ready);
endinterface

interface pti_rsp_if;
    import pti_pkg::*;

    logic                      valid;
    logic                      ready;
    logic signed [FIELD_W-1:0] param_a;
    logic signed [FIELD_W-1:0] param_b;

    modport source (output valid, param_a, param_b, input ready);
    modport sink   (input valid, param_a, param_b, output ready);
endinterface

// ===== sv/periodic_table_interpolator.sv =====
`timescale 1ns / 1ps
// A query word passes the stage registers and the row banks, then the result
// queue, before it shows on o_rsp. Throughput: one word per cycle (writes
// and queries alike) while ready is high; the row pair is read at once from
// separate even and odd row banks, one port each. Reset clears the pipeline,
// result queue and credits; table rows are undefined until written.
// ----------------------------------------------------------------------------
// periodic_table_interpolator
// Evenly spaced two-value table over a 24 h day with linear interpolation.
// ----------------------------------------------------------------------------
module periodic_table_interpolator (
    input  logic          i_clk,
    input  logic          i_rst_n,
    pti_req_if.sink       i_req,
    pti_rsp_if.source     o_rsp
);
    import pti_pkg::*;

    localparam int DIFF_W    = VALUE_BITS + 1;
    localparam int LPROD_W   = DIFF_W + FRAC_W + 1;
    localparam int SUM_W     = VALUE_BITS + 2;
    localparam int CNT_W     = FIFO_AW + 1;

    localparam logic signed [SUM_W-1:0] SAT_HI =
        SUM_W'((64'sd1 <<< (VALUE_BITS - 1)) - 64'sd1);
    localparam logic signed [SUM_W-1:0] SAT_LO = ~SAT_HI;

    // Clamp to the signed value range, then sign-extend to the port width.
    function automatic logic [FIELD_W-1:0] f_sat(input logic signed [SUM_W-1:0] v);
        logic signed [VALUE_BITS-1:0] r;
        if (v > SAT_HI) begin
            r = VALUE_BITS'(SAT_HI);
        end else if (v < SAT_LO) begin
            r = VALUE_BITS'(SAT_LO);
        end else begin
            r = VALUE_BITS'(v);
        end
        return FIELD_W'(r);
    endfunction

    // ------------------------------------------------------------------
    // Input side: accept while a queue slot is reserved for every query
    // in flight. Credits return when a result word leaves.
    // ------------------------------------------------------------------
    logic             w_req_acc;
    logic             w_query_acc;
    logic             w_pop;
    logic [CNT_W-1:0] r_credit;
    logic [CNT_W-1:0] n_credit;

    assign w_req_acc   = i_req.valid && i_req.ready;
    assign w_query_acc = w_req_acc && (i_req.func == FUNC_QUERY);
    assign w_pop       = o_rsp.valid && o_rsp.ready;
    assign i_req.ready = (r_credit != CNT_W'(FIFO_DEPTH));

    always_comb begin
        n_credit = r_credit;
        if (w_query_acc && !w_pop) begin
            n_credit = r_credit + CNT_W'(1);
        end else if (!w_query_acc && w_pop) begin
            n_credit = r_credit - CNT_W'(1);
        end
    end

    // ------------------------------------------------------------------
    // Stage 1: time modulo one day. Upper bits (multiples of 2^19) are
    // reduced mod 3 with a reciprocal multiply.
    // ------------------------------------------------------------------
    logic [MOD3_IN_W-1:0]            w_hi;
    logic [MOD3_IN_W+MOD3_SHIFT-1:0] w_m3_prod;
    logic [MOD3_IN_W-1:0]            w_m3_quot;
    logic [MOD3_IN_W+1:0]            w_m3_x3;
    logic [1:0]                      w_m3_rem;

    assign w_hi      = i_req.query_time[FIELD_W-1:DAY_SHIFT];
    assign w_m3_prod = (MOD3_IN_W+MOD3_SHIFT)'(w_hi) *
                       (MOD3_IN_W+MOD3_SHIFT)'(MOD3_RECIP);
    assign w_m3_quot = MOD3_IN_W'(w_m3_prod >> MOD3_SHIFT);
    assign w_m3_x3   = (MOD3_IN_W+2)'(w_m3_quot) + (MOD3_IN_W+2)'({w_m3_quot, 1'b0});
    assign w_m3_rem  = 2'((MOD3_IN_W+2)'(w_hi) - w_m3_x3);

    logic                   r_s1_vld;
    t_func                  r_s1_func;
    logic [IDX_W-1:0]       r_s1_widx;
    logic [ROW_BITS-1:0]    r_s1_wdata;
    logic [TDAY_W-1:0]      r_s1_t;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld <= 1'b0;
        end else begin
            r_s1_vld <= w_req_acc;
        end
        r_s1_func  <= i_req.func;
        r_s1_widx  <= i_req.row_index;
        r_s1_wdata <= {VALUE_BITS'(i_req.value_b), VALUE_BITS'(i_req.value_a)};
        r_s1_t     <= {w_m3_rem, i_req.query_time[DAY_SHIFT-1:0]};
    end

    // ------------------------------------------------------------------
    // Stage 2: scale to a Q12.16 row position.
    // ------------------------------------------------------------------
    logic [POS_PROD_W-1:0] w_pos_prod;
    logic [ROW_AW-1:0]     w_idx;

    assign w_pos_prod = POS_PROD_W'(r_s1_t) * POS_PROD_W'(ROW_SCALE);
    assign w_idx      = w_pos_prod[SCALE_SHIFT+FRAC_W +: ROW_AW];

    logic                   r_s2_vld;
    t_func                  r_s2_func;
    logic [IDX_W-1:0]       r_s2_widx;
    logic [ROW_BITS-1:0]    r_s2_wdata;
    logic [ROW_AW-1:0]      r_s2_idx;
    logic [FRAC_W-1:0]      r_s2_frac;
    logic                   r_s2_last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_vld <= 1'b0;
        end else begin
            r_s2_vld <= r_s1_vld;
        end
        r_s2_func  <= r_s1_func;
        r_s2_widx  <= r_s1_widx;
        r_s2_wdata <= r_s1_wdata;
        r_s2_idx   <= w_idx;
        r_s2_frac  <= w_pos_prod[SCALE_SHIFT +: FRAC_W];
        r_s2_last  <= (w_idx == ROW_AW'(TABLE_ROWS - 1));
    end

    // ------------------------------------------------------------------
    // Row banks: even rows and odd rows. Row idx and idx+1 always sit in
    // different banks. Writes and reads share this stage, so program
    // order between them holds without forwarding.
    // ------------------------------------------------------------------
    logic [ROW_BITS-1:0] r_even_mem [BANK_DEPTH];
    logic [ROW_BITS-1:0] r_odd_mem  [BANK_DEPTH];
    logic [ROW_BITS-1:0] r_even_q;
    logic [ROW_BITS-1:0] r_odd_q;

    logic               w_wr_en;
    logic [BANK_AW-1:0] w_wr_addr;
    logic [ROW_AW:0]    w_idx_p1;
    logic [BANK_AW-1:0] w_even_addr;
    logic [BANK_AW-1:0] w_odd_addr;

    assign w_wr_en     = r_s2_vld && (r_s2_func == FUNC_WRITE) &&
                         (32'(r_s2_widx) < TABLE_ROWS);
    assign w_wr_addr   = r_s2_widx[ROW_AW-1:1];
    assign w_idx_p1    = {1'b0, r_s2_idx} + (ROW_AW+1)'(1);
    assign w_even_addr = w_idx_p1[BANK_AW:1];
    assign w_odd_addr  = r_s2_idx[ROW_AW-1:1];

    always_ff @(posedge i_clk) begin
        if (w_wr_en && !r_s2_widx[0]) begin
            r_even_mem[w_wr_addr] <= r_s2_wdata;
        end
        r_even_q <= r_even_mem[w_even_addr];
    end

    always_ff @(posedge i_clk) begin
        if (w_wr_en && r_s2_widx[0]) begin
            r_odd_mem[w_wr_addr] <= r_s2_wdata;
        end
        r_odd_q <= r_odd_mem[w_odd_addr];
    end

    // ------------------------------------------------------------------
    // Stage 3: difference times fraction. On the last row the fraction
    // is forced to zero, so the lower (odd) row comes out unchanged.
    // ------------------------------------------------------------------
    logic               r_s3_vld;
    logic               r_s3_odd;
    logic [FRAC_W-1:0]  r_s3_frac;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s3_vld <= 1'b0;
        end else begin
            r_s3_vld <= r_s2_vld && (r_s2_func == FUNC_QUERY);
        end
        r_s3_odd  <= r_s2_idx[0];
        r_s3_frac <= r_s2_last ? '0 : r_s2_frac;
    end

    logic [ROW_BITS-1:0]          w_lo_row;
    logic [ROW_BITS-1:0]          w_hi_row;
    logic signed [VALUE_BITS-1:0] w_lo_a;
    logic signed [VALUE_BITS-1:0] w_lo_b;
    logic signed [VALUE_BITS-1:0] w_hi_a;
    logic signed [VALUE_BITS-1:0] w_hi_b;
    logic signed [DIFF_W-1:0]     w_diff_a;
    logic signed [DIFF_W-1:0]     w_diff_b;
    logic signed [FRAC_W:0]       w_frac_s;

    assign w_lo_row = r_s3_odd ? r_odd_q  : r_even_q;
    assign w_hi_row = r_s3_odd ? r_even_q : r_odd_q;
    assign w_lo_a   = w_lo_row[VALUE_BITS-1:0];
    assign w_lo_b   = w_lo_row[ROW_BITS-1:VALUE_BITS];
    assign w_hi_a   = w_hi_row[VALUE_BITS-1:0];
    assign w_hi_b   = w_hi_row[ROW_BITS-1:VALUE_BITS];
    assign w_diff_a = DIFF_W'(w_hi_a) - DIFF_W'(w_lo_a);
    assign w_diff_b = DIFF_W'(w_hi_b) - DIFF_W'(w_lo_b);
    assign w_frac_s = $signed({1'b0, r_s3_frac});

    logic                         r_s4_vld;
    logic signed [LPROD_W-1:0]    r_s4_prod_a;
    logic signed [LPROD_W-1:0]    r_s4_prod_b;
    logic signed [VALUE_BITS-1:0] r_s4_lo_a;
    logic signed [VALUE_BITS-1:0] r_s4_lo_b;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s4_vld <= 1'b0;
        end else begin
            r_s4_vld <= r_s3_vld;
        end
        r_s4_prod_a <= LPROD_W'(w_diff_a) * LPROD_W'(w_frac_s);
        r_s4_prod_b <= LPROD_W'(w_diff_b) * LPROD_W'(w_frac_s);
        r_s4_lo_a   <= w_lo_a;
        r_s4_lo_b   <= w_lo_b;
    end

    // ------------------------------------------------------------------
    // Stage 4: floor-shift, add the lower row, saturate, queue.
    // ------------------------------------------------------------------
    logic signed [SUM_W-1:0] w_sum_a;
    logic signed [SUM_W-1:0] w_sum_b;

    assign w_sum_a = SUM_W'(r_s4_prod_a >>> FRAC_W) + SUM_W'(r_s4_lo_a);
    assign w_sum_b = SUM_W'(r_s4_prod_b >>> FRAC_W) + SUM_W'(r_s4_lo_b);

    // Result queue; credits keep it from overflowing.
    logic [FIELD_W-1:0] r_fifo_a [FIFO_DEPTH];
    logic [FIELD_W-1:0] r_fifo_b [FIFO_DEPTH];
    logic [FIFO_AW-1:0] r_wptr;
    logic [FIFO_AW-1:0] r_rptr;
    logic [CNT_W-1:0]   r_fcount;
    logic [CNT_W-1:0]   n_fcount;

    always_comb begin
        n_fcount = r_fcount;
        if (r_s4_vld && !w_pop) begin
            n_fcount = r_fcount + CNT_W'(1);
        end else if (!r_s4_vld && w_pop) begin
            n_fcount = r_fcount - CNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_s4_vld) begin
            r_fifo_a[r_wptr] <= f_sat(w_sum_a);
            r_fifo_b[r_wptr] <= f_sat(w_sum_b);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr   <= '0;
            r_rptr   <= '0;
            r_fcount <= '0;
            r_credit <= '0;
        end else begin
            if (r_s4_vld) begin
                r_wptr <= r_wptr + FIFO_AW'(1);
            end
            if (w_pop) begin
                r_rptr <= r_rptr + FIFO_AW'(1);
            end
            r_fcount <= n_fcount;
            r_credit <= n_credit;
        end
    end

    assign o_rsp.valid   = (r_fcount != '0);
    assign o_rsp.param_a = r_fifo_a[r_rptr];
    assign o_rsp.param_b = r_fifo_b[r_rptr];

endmodule

// ===== sv/pti_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pti_checker
// Port-level checks of the periodic table interpolator.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module pti_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_req_valid,
    input logic        i_req_ready,
    input logic        i_rsp_valid,
    input logic        i_rsp_ready,
    input logic [31:0] i_param_a,
    input logic [31:0] i_param_b
);

    // Result word holds until taken.
    `PTI_ASSERT_NEXT(a_rsp_hold, i_clk, i_rst_n, i_rsp_valid && !i_rsp_ready, i_rsp_valid, "result word dropped while stalled")

    // Stalled result payload does not change.
    `PTI_ASSERT_NEXT(a_rsp_stable, i_clk, i_rst_n, i_rsp_valid && !i_rsp_ready, $stable(i_param_a) && $stable(i_param_b), "result payload changed while stalled")

    // Credits only grow on an accepted word, so ready cannot drop on an idle input.
    `PTI_ASSERT_NEXT(a_ready_idle, i_clk, i_rst_n, i_req_ready && !i_req_valid, i_req_ready, "ready dropped without an accepted word")

    // Reset empties the queue and frees all credits.
    `PTI_ASSERT_NEXT_ALWAYS(a_reset_state, i_clk, !i_rst_n, !i_rsp_valid && i_req_ready, "state not cleared by reset")

endmodule

bind periodic_table_interpolator pti_checker u_pti_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_req_valid (i_req.valid),
    .i_req_ready (i_req.ready),
    .i_rsp_valid (o_rsp.valid),
    .i_rsp_ready (o_rsp.ready),
    .i_param_a   (o_rsp.param_a),
    .i_param_b   (o_rsp.param_b)
);

// ===== verif/tb_periodic_table_interpolator.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_periodic_table_interpolator
// Self-checking bench for the periodic table interpolator. A few row windows
// are preloaded before any query: both ends of the table and the rows around
// 8 h and 16 h. Queries only land on segments whose two rows are already
// written, so no unwritten row is ever read. A short directed list covers
// extreme rows, exact row hits and day wrap. A random write/query mix follows,
// with random gaps on both channels and one long result-side hold. Every query
// is checked against a local predictor or against a value given with it.
// ----------------------------------------------------------------------------
module tb_periodic_table_interpolator;
    import pti_pkg::*;

    localparam longint unsigned DAY_TICKS = 64'd24 << FRAC_W;   // 24 h in Q16.16
    localparam longint unsigned HOURS     = 64'd24;
    localparam longint          VAL_MAX   = 64'sd2147483647;
    localparam longint          VAL_MIN   = -64'sd2147483648;
    localparam int              RAND_WORDS = 450;
    localparam int              LONG_HOLD  = 64;
    localparam int              BURST_LEN  = 40;
    localparam int              MAX_SHOWN  = 10;
    // preloaded row windows
    localparam int              EDGE_ROWS  = 64;
    localparam int              MID_ROWS   = 60;
    localparam int              MID1_LO    = 1340;
    localparam int              MID2_LO    = 2700;
    localparam int              SEG_TRIES  = 64;
    // whole days that still keep a query time inside 32 bits
    localparam int              MAX_DAYS   =
        int'((64'h1_0000_0000 - DAY_TICKS) / DAY_TICKS) - 1;

    typedef struct packed {
        logic [31:0] a;
        logic [31:0] b;
    } t_param_pair;

    typedef struct packed {
        t_func       func;
        logic [11:0] row;
        logic [31:0] va;
        logic [31:0] vb;
        logic [31:0] qt;
        logic        has_exp;
        logic [31:0] exp_a;
        logic [31:0] exp_b;
    } t_stim_word;

    logic i_clk;
    logic i_rst_n;

    pti_req_if req_if ();
    pti_rsp_if rsp_if ();

    periodic_table_interpolator dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_if),
        .o_rsp   (rsp_if)
    );

    // shadow copy of the row store
    logic [31:0] shadow_a [TABLE_ROWS];
    logic [31:0] shadow_b [TABLE_ROWS];
    bit          row_written [TABLE_ROWS];

    t_param_pair expected_params [$];
    t_stim_word  directed_words [$];

    int  mismatches;
    int  results_seen;
    int  writes_sent;
    int  queries_sent;
    int  input_stalls;
    bit  hold_req;
    bit  tx_calm;

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    initial begin
        #20_000_000;
        $display("tb: failure");
        $finish;
    end

    // ---------------- predictor ----------------
    function automatic logic [31:0] lerp_q16(logic [31:0] lo, logic [31:0] hi,
                                             logic [15:0] frac);
        longint lo_s;
        longint hi_s;
        longint sum;
        lo_s = longint'($signed(lo));
        hi_s = longint'($signed(hi));
        // arithmetic shift rounds toward minus infinity
        sum  = lo_s + (((hi_s - lo_s) * longint'({1'b0, frac})) >>> FRAC_W);
        if (sum > VAL_MAX)
            sum = VAL_MAX;
        else if (sum < VAL_MIN)
            sum = VAL_MIN;
        return sum[31:0];
    endfunction

    function automatic t_param_pair interp_params(logic [31:0] qt);
        longint unsigned t;
        longint unsigned pos;
        int              idx;
        logic [15:0]     frac;
        t_param_pair     r;
        t    = longint'(qt) % DAY_TICKS;
        pos  = (t * longint'(TABLE_ROWS - 1)) / HOURS;
        idx  = int'(pos >> FRAC_W);
        frac = pos[15:0];
        if (idx >= TABLE_ROWS - 1) begin
            // no row past the table: last row as stored
            r.a = shadow_a[TABLE_ROWS-1];
            r.b = shadow_b[TABLE_ROWS-1];
        end else begin
            r.a = lerp_q16(shadow_a[idx], shadow_a[idx+1], frac);
            r.b = lerp_q16(shadow_b[idx], shadow_b[idx+1], frac);
        end
        return r;
    endfunction

    // ---------------- stimulus helpers ----------------
    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (tx_calm || r < 55)
            return 0;
        else if (r < 90)
            return $urandom_range(1, 3);
        return $urandom_range(6, 25);
    endfunction

    function automatic logic [31:0] rand_value();
        case ($urandom_range(0, 11))
            0:       return 32'h8000_0000;
            1:       return 32'h7FFF_FFFF;
            2:       return 32'h0000_0000;
            3:       return 32'hFFFF_FFFF;
            default: return $urandom;
        endcase
    endfunction

    function automatic bit in_window(int r);
        return (r < EDGE_ROWS) || (r >= TABLE_ROWS - EDGE_ROWS) ||
               (r >= MID1_LO && r < MID1_LO + MID_ROWS) ||
               (r >= MID2_LO && r < MID2_LO + MID_ROWS);
    endfunction

    // Segment whose lower and upper rows are both written.
    function automatic int pick_seg();
        int seg;
        for (int i = 0; i < SEG_TRIES; i++) begin
            seg = int'($urandom_range(0, TABLE_ROWS - 2));
            if (row_written[seg] && row_written[seg + 1])
                return seg;
        end
        // fall back to a preloaded window
        case ($urandom_range(0, 3))
            0:       return int'($urandom_range(0, EDGE_ROWS - 2));
            1:       return int'($urandom_range(MID1_LO, MID1_LO + MID_ROWS - 2));
            2:       return int'($urandom_range(MID2_LO, MID2_LO + MID_ROWS - 2));
            default: return int'($urandom_range(TABLE_ROWS - EDGE_ROWS, TABLE_ROWS - 2));
        endcase
    endfunction

    // Query time that lands in the given segment, sometimes some days later.
    function automatic logic [31:0] seg_time(int seg);
        longint unsigned t_lo;
        longint unsigned t_hi;
        longint unsigned t;
        int              r;
        int              days;
        t_lo = ((longint'(seg) << FRAC_W) * HOURS + longint'(TABLE_ROWS - 2))
               / longint'(TABLE_ROWS - 1);
        t_hi = ((longint'(seg + 1) << FRAC_W) * HOURS + longint'(TABLE_ROWS - 2))
               / longint'(TABLE_ROWS - 1) - 64'd1;
        r = $urandom_range(0, 9);
        if (r == 0)
            t = t_lo;           // first time in the segment
        else if (r == 1)
            t = t_hi;           // fraction close to one
        else
            t = t_lo + longint'($urandom_range(0, int'(t_hi - t_lo)));
        days = 0;
        if ($urandom_range(0, 3) == 0)
            days = $urandom_range(0, MAX_DAYS);
        t = t + longint'(days) * DAY_TICKS;
        return t[31:0];
    endfunction

    function automatic logic [31:0] rand_query_time();
        return seg_time(pick_seg());
    endfunction

    function automatic void queue_word(t_stim_word w);
        directed_words.insert(directed_words.size(), w);
    endfunction

    function automatic void add_write(logic [11:0] row, logic [31:0] va, logic [31:0] vb);
        t_stim_word w;
        w = '{FUNC_WRITE, row, va, vb, $urandom, 1'b0, 32'd0, 32'd0};
        queue_word(w);
    endfunction

    function automatic void add_query(logic [31:0] qt);
        t_stim_word w;
        w = '{FUNC_QUERY, 12'($urandom), $urandom, $urandom, qt, 1'b0, 32'd0, 32'd0};
        queue_word(w);
    endfunction

    function automatic void add_query_exact(logic [31:0] qt, logic [31:0] ea,
                                            logic [31:0] eb);
        t_stim_word w;
        w = '{FUNC_QUERY, 12'($urandom), $urandom, $urandom, qt, 1'b1, ea, eb};
        queue_word(w);
    endfunction

    task automatic pause(int n);
        if (n > 0) begin
            req_if.valid <= 1'b0;
            repeat (n) @(negedge i_clk);
        end
    endtask

    // Drive one word at a falling edge, hold it until taken, then account for it.
    task automatic send_word(t_stim_word w);
        t_param_pair want;
        req_if.valid      <= 1'b1;
        req_if.func       <= w.func;
        req_if.row_index  <= w.row;
        req_if.value_a    <= w.va;
        req_if.value_b    <= w.vb;
        req_if.query_time <= w.qt;
        do @(posedge i_clk); while (!req_if.ready);
        if (w.func == FUNC_WRITE) begin
            shadow_a[w.row]    = w.va;
            shadow_b[w.row]    = w.vb;
            row_written[w.row] = 1'b1;
            writes_sent++;
        end else begin
            if (w.has_exp)
                want = '{w.exp_a, w.exp_b};
            else
                want = interp_params(w.qt);
            expected_params.insert(expected_params.size(), want);
            queries_sent++;
        end
        @(negedge i_clk);
    endtask

    function automatic t_stim_word rand_write();
        int          r;
        logic [11:0] row;
        r = $urandom_range(0, 9);
        if (r == 0)
            row = 12'($urandom_range(0, 1));
        else if (r == 1)
            row = 12'($urandom_range(TABLE_ROWS - 2, TABLE_ROWS - 1));
        else
            row = 12'($urandom_range(0, TABLE_ROWS - 1));
        return '{FUNC_WRITE, row, rand_value(), rand_value(), $urandom, 1'b0, 32'd0, 32'd0};
    endfunction

    function automatic t_stim_word rand_query();
        return '{FUNC_QUERY, 12'($urandom), $urandom, $urandom, rand_query_time(),
                 1'b0, 32'd0, 32'd0};
    endfunction

    task automatic flag_error(string msg);
        mismatches++;
        if (mismatches <= MAX_SHOWN)
            $display("%0t: %s", $time, msg);
    endtask

    // ---------------- result checker ----------------
    always @(posedge i_clk) begin
        t_param_pair want;
        if (i_rst_n && req_if.valid && !req_if.ready)
            input_stalls++;
        if (i_rst_n && rsp_if.valid && rsp_if.ready) begin
            results_seen++;
            if (expected_params.size() == 0) begin
                flag_error($sformatf("result with none pending: a=%h b=%h",
                                     rsp_if.param_a, rsp_if.param_b));
            end else begin
                want = expected_params.pop_front();
                if (rsp_if.param_a !== want.a)
                    flag_error($sformatf("param_a: expected %h, got %h",
                                         want.a, rsp_if.param_a));
                if (rsp_if.param_b !== want.b)
                    flag_error($sformatf("param_b: expected %h, got %h",
                                         want.b, rsp_if.param_b));
            end
        end
    end

    // ---------------- result-side ready ----------------
    initial begin : rx_side
        int hold_left;
        int run;
        int r;
        bit level;
        hold_left = 0;
        run       = 0;
        level     = 1'b0;
        rsp_if.ready = 1'b0;
        wait (i_rst_n === 1'b1);
        forever begin
            @(negedge i_clk);
            if (hold_left > 0) begin
                rsp_if.ready <= 1'b0;
                hold_left--;
            end else if (hold_req) begin
                // long hold so the result queue fills and the input backs up
                hold_req  = 1'b0;
                hold_left = LONG_HOLD - 1;
                rsp_if.ready <= 1'b0;
            end else begin
                if (run == 0) begin
                    r = $urandom_range(0, 99);
                    if (r < 60) begin
                        level = 1'b1;
                        run   = $urandom_range(1, 30);
                    end else if (r < 92) begin
                        level = 1'b0;
                        run   = $urandom_range(1, 3);
                    end else begin
                        level = 1'b0;
                        run   = $urandom_range(8, 30);
                    end
                end
                rsp_if.ready <= level;
                run--;
            end
        end
    end

    // ---------------- main sequence ----------------
    initial begin : stimulus
        int n;
        int k;
        mismatches   = 0;
        results_seen = 0;
        writes_sent  = 0;
        queries_sent = 0;
        input_stalls = 0;
        hold_req     = 1'b0;
        tx_calm      = 1'b0;

        req_if.valid      = 1'b0;
        req_if.func       = FUNC_WRITE;
        req_if.row_index  = '0;
        req_if.value_a    = '0;
        req_if.value_b    = '0;
        req_if.query_time = '0;
        i_rst_n           = 1'b0;
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Preload the row windows that queries are allowed to touch.
        for (int r = 0; r < TABLE_ROWS; r++) begin
            if (in_window(r)) begin
                pause(gap_len());
                send_word('{FUNC_WRITE, 12'(r), rand_value(), rand_value(), $urandom,
                            1'b0, 32'd0, 32'd0});
            end
        end

        // Directed list. Rows 1365 and 2730 sit exactly at 8 h and 16 h.
        add_write(12'd0,    32'h7FFF_FFFF, 32'h8000_0000);
        add_write(12'd1,    32'h8000_0000, 32'h7FFF_FFFF);
        add_write(12'd1365, 32'h0001_8000, 32'hFFFF_0000);
        add_write(12'd1366, 32'h0001_8000, 32'hFFFF_0000);   // flat segment
        add_write(12'd2730, 32'h0000_0000, 32'hFFFF_FFFF);
        add_write(12'd4094, 32'h1234_5678, 32'h8765_4321);
        add_write(12'd4095, 32'h8000_0000, 32'h7FFF_FFFF);
        add_query_exact(32'd0,              32'h7FFF_FFFF, 32'h8000_0000);
        add_query_exact(32'd24 << 16,       32'h7FFF_FFFF, 32'h8000_0000);  // one day wraps
        add_query_exact(32'd8 << 16,        32'h0001_8000, 32'hFFFF_0000);
        add_query_exact(32'd16 << 16,       32'h0000_0000, 32'hFFFF_FFFF);
        add_query_exact(32'd32 << 16,       32'h0001_8000, 32'hFFFF_0000);  // 8 h next day
        add_query_exact((32'd8 << 16) + 100, 32'h0001_8000, 32'hFFFF_0000); // inside flat
        add_query(32'd1);                   // full-range swing, tiny fraction
        add_query(32'd192);                 // about half way between rows 0 and 1
        add_query(32'd383);                 // fraction close to one
        add_query(32'(DAY_TICKS) - 32'd1);  // last instant of the day
        add_query(32'(DAY_TICKS) - 32'd385);
        add_query(32'hFFFF_FFFF);
        add_query(32'h8000_0000);
        add_write(12'd0, 32'h0000_0000, 32'h0000_0000);
        add_query_exact(32'd0, 32'h0000_0000, 32'h0000_0000);   // write then read back

        foreach (directed_words[i]) begin
            pause(gap_len());
            send_word(directed_words[i]);
        end

        // Random mix, with one back-to-back query burst against a long hold.
        n = 0;
        while (n < RAND_WORDS) begin
            if (n % 64 == 0)
                tx_calm = ($urandom_range(0, 3) == 0);
            if (n == 200) begin
                hold_req = 1'b1;
                for (k = 0; k < BURST_LEN; k++)
                    send_word(rand_query());
                n += BURST_LEN;
            end else begin
                pause(gap_len());
                if ($urandom_range(0, 99) < 65)
                    send_word(rand_query());
                else
                    send_word(rand_write());
                n++;
            end
        end
        req_if.valid <= 1'b0;

        while (expected_params.size() != 0)
            @(posedge i_clk);
        repeat (16) @(posedge i_clk);
        if (expected_params.size() != 0)
            flag_error($sformatf("%0d results never arrived", expected_params.size()));

        $display("run: %0d row writes, %0d queries, %0d results checked",
                 writes_sent, queries_sent, results_seen);
        $display("run: %0d input back-pressure cycles, %0d mismatches",
                 input_stalls, mismatches);
        if (mismatches == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule

// ===== periodic_table_interpolator.f =====
+incdir+sv
sv/pti_pkg.sv
sv/pti_if.sv
sv/periodic_table_interpolator.sv
sv/pti_checker.sv
verif/tb_periodic_table_interpolator.sv
